// File: src/command_packet_framer_macros.svh
// Assertion macros shared by the command packet framer RTL.
`ifndef COMMAND_PACKET_FRAMER_MACROS_SVH
`define COMMAND_PACKET_FRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cpf_pkg.sv
// Package with the types, codes and sizes of the command packet framer.
`timescale 1ns / 1ps

package cpf_pkg;

  // Largest payload length that a length byte may announce.
  localparam int MAX_PAYLOAD = 16;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_CLASS_MASK  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_BYTE_CODE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_BYTE_CODE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_BYTE_CODE  = 8'd3;

  // Configuration reset values.
  localparam logic [7:0] RST_SIZE_CLASS_MASK  = 8'd192;
  localparam logic [7:0] RST_SINGLE_BYTE_CODE = 8'd0;
  localparam logic [7:0] RST_TWO_BYTE_CODE    = 8'd64;
  localparam logic [7:0] RST_MULTI_BYTE_CODE  = 8'd128;

  // Framer phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  // Result event kinds.
  localparam logic [1:0] KIND_DONE     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG = 2'd3;

  // One received input item.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] command_code;
    logic [7:0] payload_index;
    logic [7:0] payload_value;
    logic       packet_end;
  } res_item_t;

  // Current configuration register values.
  typedef struct packed {
    logic [7:0] size_class_mask;
    logic [7:0] single_byte_code;
    logic [7:0] two_byte_code;
    logic [7:0] multi_byte_code;
  } cfg_t;

  // Framer running state, exported for checking.
  typedef struct packed {
    logic [1:0]       phase;
    logic [LEN_W-1:0] expected_length;
    logic [LEN_W-1:0] received_count;
  } status_t;

endpackage

// File: src/cpf_in_if.sv
// Interface of the received byte channel.
`timescale 1ns / 1ps

interface cpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_error;

  modport source (output valid, output rx_byte, output line_error, input ready);
  modport sink (input valid, input rx_byte, input line_error, output ready);
endinterface

// File: src/cpf_out_if.sv
// Interface of the framer event channel.
`timescale 1ns / 1ps

interface cpf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] command_code;
  logic [7:0] payload_index;
  logic [7:0] payload_value;
  logic       packet_end;

  modport source (
    output valid, output event_kind, output command_code, output payload_index,
    output payload_value, output packet_end, input ready
  );
  modport sink (
    input valid, input event_kind, input command_code, input payload_index,
    input payload_value, input packet_end, output ready
  );
endinterface

// File: src/cpf_cfg_if.sv
// Interface of the configuration write channel.
`timescale 1ns / 1ps

interface cpf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cpf_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/command_packet_framer.sv
// Top level of the command packet framer.
`timescale 1ns / 1ps
`include "command_packet_framer_macros.svh"

// Frames command packets from received serial bytes and reports one event per
// completed command, payload byte or rejected packet. Bytes flagged with a line
// error and zero bytes between packets produce no event. The block takes one
// byte every clock cycle unless the input is held back. A byte passes an input
// register and then the framing logic into a result register, from which its
// event is presented. The input is held back only while both the input register
// and the result register are full and the event channel is not ready.
// Configuration registers are written through the cfg channel, which is always
// ready; writes to indexes past the last register are dropped.
module command_packet_framer (
  input  logic             clk,
  input  logic             rst_n,
  cpf_in_if.sink           in_ch,
  cpf_out_if.source        out_ch,
  cpf_cfg_if.sink          cfg_ch
);

  cpf_pkg::cfg_t      cfg;
  cpf_pkg::in_item_t  in_item;
  cpf_pkg::in_item_t  s1_item;
  logic               s1_valid;
  logic               s1_take;
  cpf_pkg::res_item_t res;
  cpf_pkg::status_t   status;

  assign in_item.rx_byte    = in_ch.rx_byte;
  assign in_item.line_error = in_ch.line_error;

  // Configuration registers.
  cpf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // Input register.
  cpf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .take       (s1_take),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  // Framing logic and result register.
  cpf_frame_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_valid),
    .item       (s1_item),
    .take       (s1_take),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (res),
    .status     (status)
  );

  assign out_ch.event_kind    = res.event_kind;
  assign out_ch.command_code  = res.command_code;
  assign out_ch.payload_index = res.payload_index;
  assign out_ch.payload_value = res.payload_value;
  assign out_ch.packet_end    = res.packet_end;

  // While payload is expected, the count stays below a legal nonzero length.
  `CPF_ASSERT_NOW(a_payload_count, status.phase == cpf_pkg::PH_PAYLOAD, (status.expected_length != '0) && (status.received_count < status.expected_length) && (status.expected_length <= cpf_pkg::LEN_W'(cpf_pkg::MAX_PAYLOAD)), "payload count out of range")

  // Input back-pressure only happens with a byte waiting in the input register.
  `CPF_ASSERT_NOW(a_ready_backpressure, !in_ch.ready, s1_valid && out_ch.valid && !out_ch.ready, "input stalled without a full pipeline")

  // A new event only appears after a byte left the input register.
  `CPF_ASSERT_NOW(a_event_source, $rose(out_ch.valid), $past(s1_take), "event without a framed byte")

  // An accepted byte always lands in the input register.
  `CPF_ASSERT_NEXT(a_in_loaded, in_ch.valid && in_ch.ready, s1_valid, "accepted byte lost")

endmodule

// File: src/cpf_cfg_regs.sv
// Configuration register file of the command packet framer.
`timescale 1ns / 1ps

module cpf_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_valid,
  output logic                          wr_ready,
  input  logic [cpf_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]                    wr_data,
  output cpf_pkg::cfg_t                 cfg
);

  cpf_pkg::cfg_t cfg_r;

  // Writes are always taken; an index beyond the list is dropped.
  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_class_mask  <= cpf_pkg::RST_SIZE_CLASS_MASK;
      cfg_r.single_byte_code <= cpf_pkg::RST_SINGLE_BYTE_CODE;
      cfg_r.two_byte_code    <= cpf_pkg::RST_TWO_BYTE_CODE;
      cfg_r.multi_byte_code  <= cpf_pkg::RST_MULTI_BYTE_CODE;
    end else if (wr_valid && wr_ready) begin
      unique case (wr_index)
        cpf_pkg::CFG_SIZE_CLASS_MASK:  cfg_r.size_class_mask  <= wr_data;
        cpf_pkg::CFG_SINGLE_BYTE_CODE: cfg_r.single_byte_code <= wr_data;
        cpf_pkg::CFG_TWO_BYTE_CODE:    cfg_r.two_byte_code    <= wr_data;
        cpf_pkg::CFG_MULTI_BYTE_CODE:  cfg_r.multi_byte_code  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/cpf_in_stage.sv
// Input register stage that holds one received item for the framer.
`timescale 1ns / 1ps

module cpf_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpf_pkg::in_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output cpf_pkg::in_item_t item
);

  logic              valid_r;
  logic              valid_nxt;
  cpf_pkg::in_item_t item_r;

  // The stage can load when empty or when its item leaves this cycle.
  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: src/cpf_frame_core.sv
// Framing state machine and result register of the command packet framer.
`timescale 1ns / 1ps

module cpf_frame_core (
  input  logic               clk,
  input  logic               rst_n,
  input  cpf_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  cpf_pkg::in_item_t  item,
  output logic               take,
  output logic               res_valid,
  input  logic               res_ready,
  output cpf_pkg::res_item_t res,
  output cpf_pkg::status_t   status
);

  logic [1:0]                phase_r;
  logic [1:0]                phase_nxt;
  logic [7:0]                held_r;
  logic [7:0]                held_nxt;
  logic [cpf_pkg::LEN_W-1:0] exp_r;
  logic [cpf_pkg::LEN_W-1:0] exp_nxt;
  logic [cpf_pkg::LEN_W-1:0] cnt_r;
  logic [cpf_pkg::LEN_W-1:0] cnt_nxt;
  logic [cpf_pkg::LEN_W:0]   cnt_inc;
  logic [7:0]                cls;
  logic                      emit;
  cpf_pkg::res_item_t        ev;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  cpf_pkg::res_item_t        out_r;

  // An item moves on whenever the result register is free or being emptied.
  assign take = item_valid && (!out_valid_r || res_ready);

  assign cls     = item.rx_byte & cfg.size_class_mask;
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;

  // Next framing state and the event, if any, for the held item.
  always_comb begin
    phase_nxt        = phase_r;
    held_nxt         = held_r;
    exp_nxt          = exp_r;
    cnt_nxt          = cnt_r;
    emit             = 1'b0;
    ev.event_kind    = cpf_pkg::KIND_DONE;
    ev.command_code  = held_r;
    ev.payload_index = 8'd0;
    ev.payload_value = 8'd0;
    ev.packet_end    = 1'b1;
    if (!item.line_error) begin
      unique case (phase_r)
        cpf_pkg::PH_LENGTH: begin
          priority if (item.rx_byte == 8'd0) begin
            // An empty payload ends the packet at the length byte.
            phase_nxt = cpf_pkg::PH_IDLE;
            emit      = 1'b1;
          end else if (item.rx_byte > cpf_pkg::MAX_PAYLOAD_B) begin
            phase_nxt     = cpf_pkg::PH_IDLE;
            emit          = 1'b1;
            ev.event_kind = cpf_pkg::KIND_TOO_LONG;
          end else begin
            exp_nxt   = item.rx_byte[cpf_pkg::LEN_W-1:0];
            cnt_nxt   = '0;
            phase_nxt = cpf_pkg::PH_PAYLOAD;
          end
        end
        cpf_pkg::PH_PAYLOAD: begin
          cnt_nxt          = cnt_inc[cpf_pkg::LEN_W-1:0];
          emit             = 1'b1;
          ev.event_kind    = cpf_pkg::KIND_PAYLOAD;
          ev.payload_index = 8'(cnt_r);
          ev.payload_value = item.rx_byte;
          ev.packet_end    = (cnt_inc >= {1'b0, exp_r});
          if (ev.packet_end) begin
            phase_nxt = cpf_pkg::PH_IDLE;
          end
        end
        default: begin
          // Idle, and the unused phase code behaves the same.
          phase_nxt = cpf_pkg::PH_IDLE;
          if (item.rx_byte != 8'd0) begin
            held_nxt        = item.rx_byte;
            ev.command_code = item.rx_byte;
            priority if (cls == cfg.single_byte_code) begin
              emit = 1'b1;
            end else if (cls == cfg.two_byte_code) begin
              exp_nxt   = cpf_pkg::LEN_W'(1);
              cnt_nxt   = '0;
              phase_nxt = cpf_pkg::PH_PAYLOAD;
            end else if (cls == cfg.multi_byte_code) begin
              cnt_nxt   = '0;
              phase_nxt = cpf_pkg::PH_LENGTH;
            end else begin
              emit          = 1'b1;
              ev.event_kind = cpf_pkg::KIND_UNKNOWN;
            end
          end
        end
      endcase
    end
  end

  // Result register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = emit;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cpf_pkg::PH_IDLE;
      held_r      <= 8'd0;
      exp_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        exp_r   <= exp_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // Result payload register needs no reset.
  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_r <= ev;
    end
  end

  assign res_valid              = out_valid_r;
  assign res                    = out_r;
  assign status.phase           = phase_r;
  assign status.expected_length = exp_r;
  assign status.received_count  = cnt_r;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the command packet framer.
`timescale 1ns / 1ps

module tb;
  import cpf_pkg::*;

  // Cycles with no handshake on any channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;
  // Input items per random phase.
  localparam int PHASE_ITEMS = 186;
  localparam int PHASE_COUNT = 9;

  // Packet forms, as the size class of a command byte selects them.
  typedef enum int {FORM_SINGLE, FORM_TWO, FORM_MULTI, FORM_UNKNOWN} form_t;

  // One row of the directed table. Where typed is set, the row carries its own
  // expected result (or none); otherwise the framer model supplies it.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    logic      has_event;
    res_item_t want;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [23] = '{
    // Idle filler and a line error while idle.
    '{'{8'h00, 1'b0}, 1'b1, 1'b0, '0},
    '{'{8'hFF, 1'b1}, 1'b1, 1'b0, '0},
    // Command without payload, then an unknown size class.
    '{'{8'h01, 1'b0}, 1'b1, 1'b1, '{KIND_DONE, 8'h01, 8'h00, 8'h00, 1'b1}},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b1, '{KIND_UNKNOWN, 8'hFF, 8'h00, 8'h00, 1'b1}},
    // Two-byte command whose payload is a zero byte.
    '{'{8'h41, 1'b0}, 1'b0, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h41, 8'h00, 8'h00, 1'b1}},
    // Two-byte command with a line error in front of its payload.
    '{'{8'h7F, 1'b0}, 1'b0, 1'b0, '0},
    '{'{8'hAA, 1'b1}, 1'b1, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h7F, 8'h00, 8'hFF, 1'b1}},
    // Length byte of zero completes the packet.
    '{'{8'h80, 1'b0}, 1'b0, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b1, 1'b1, '{KIND_DONE, 8'h80, 8'h00, 8'h00, 1'b1}},
    // Lengths just above the buffer and at the top of the range.
    '{'{8'hBF, 1'b0}, 1'b0, 1'b0, '0},
    '{'{8'h11, 1'b0}, 1'b1, 1'b1, '{KIND_TOO_LONG, 8'hBF, 8'h00, 8'h00, 1'b1}},
    '{'{8'h81, 1'b0}, 1'b0, 1'b0, '0},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b1, '{KIND_TOO_LONG, 8'h81, 8'h00, 8'h00, 1'b1}},
    // Multi-byte packet with a line error on the length byte.
    '{'{8'h82, 1'b0}, 1'b0, 1'b0, '0},
    '{'{8'h10, 1'b1}, 1'b1, 1'b0, '0},
    '{'{8'h02, 1'b0}, 1'b0, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h82, 8'h00, 8'h00, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h82, 8'h01, 8'hFF, 1'b1}},
    '{'{8'h3F, 1'b0}, 1'b1, 1'b1, '{KIND_DONE, 8'h3F, 8'h00, 8'h00, 1'b1}},
    '{'{8'hC0, 1'b1}, 1'b1, 1'b0, '0},
    '{'{8'hC0, 1'b0}, 1'b1, 1'b1, '{KIND_UNKNOWN, 8'hC0, 8'h00, 8'h00, 1'b1}}
  };

  logic clk;
  logic rst_n;

  cpf_in_if  in_ch ();
  cpf_out_if out_ch ();
  cpf_cfg_if cfg_ch ();

  command_packet_framer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Framer model state and its copy of the configuration registers.
  cfg_t       framer_regs = '{RST_SIZE_CLASS_MASK, RST_SINGLE_BYTE_CODE,
                              RST_TWO_BYTE_CODE, RST_MULTI_BYTE_CODE};
  logic [1:0] fr_phase = PH_IDLE;
  logic [7:0] fr_cmd = 8'h00;
  logic [7:0] fr_len = 8'h00;
  logic [7:0] fr_count = 8'h00;

  res_item_t  pending_events [$];
  in_item_t   byte_stream [$];
  int         fail_count = 0;
  int         quiet_cycles = 0;
  int         send_gap_pct;
  int         recv_stall_pct;

  // Expectation attached to the item currently offered on the input.
  logic       cur_typed;
  logic       cur_has_event;
  res_item_t  cur_want;

  always #2 clk = ~clk;

  // Result with the held command filled in.
  function automatic res_item_t framer_event(input logic [1:0] kind, input logic [7:0] idx,
                                             input logic [7:0] val, input logic last);
    framer_event = '{kind, fr_cmd, idx, val, last};
  endfunction

  // Advances the framer model by one byte; returns 1 when the byte makes an event.
  function automatic bit frame_byte(input in_item_t it, output res_item_t ev);
    logic [7:0] cls;
    logic [7:0] idx;
    bit         last;
    ev = '0;
    if (it.line_error) return 0;
    case (fr_phase)
      PH_LENGTH: begin
        fr_phase = PH_IDLE;
        if (it.rx_byte == 8'h00) begin
          ev = framer_event(KIND_DONE, 8'h00, 8'h00, 1'b1);
          return 1;
        end
        if (it.rx_byte > MAX_PAYLOAD_B) begin
          ev = framer_event(KIND_TOO_LONG, 8'h00, 8'h00, 1'b1);
          return 1;
        end
        fr_len = it.rx_byte;
        fr_count = 8'h00;
        fr_phase = PH_PAYLOAD;
        return 0;
      end
      PH_PAYLOAD: begin
        idx = fr_count;
        last = (int'(idx) + 1) >= int'(fr_len);
        fr_count = idx + 8'd1;
        if (last) fr_phase = PH_IDLE;
        ev = framer_event(KIND_PAYLOAD, idx, it.rx_byte, last);
        return 1;
      end
      default: begin
        fr_phase = PH_IDLE;
        if (it.rx_byte == 8'h00) return 0;
        fr_cmd = it.rx_byte;
        cls = it.rx_byte & framer_regs.size_class_mask;
        if (cls == framer_regs.single_byte_code) begin
          ev = framer_event(KIND_DONE, 8'h00, 8'h00, 1'b1);
          return 1;
        end
        if (cls == framer_regs.two_byte_code) begin
          fr_len = 8'd1;
          fr_count = 8'h00;
          fr_phase = PH_PAYLOAD;
          return 0;
        end
        if (cls == framer_regs.multi_byte_code) begin
          fr_count = 8'h00;
          fr_phase = PH_LENGTH;
          return 0;
        end
        ev = framer_event(KIND_UNKNOWN, 8'h00, 8'h00, 1'b1);
        return 1;
      end
    endcase
  endfunction

  // Packet form that a command byte takes under the current registers.
  function automatic form_t form_of(input logic [7:0] cmd);
    logic [7:0] cls;
    cls = cmd & framer_regs.size_class_mask;
    if (cls == framer_regs.single_byte_code) return FORM_SINGLE;
    if (cls == framer_regs.two_byte_code) return FORM_TWO;
    if (cls == framer_regs.multi_byte_code) return FORM_MULTI;
    return FORM_UNKNOWN;
  endfunction

  // Appends a clean byte, now and then preceded by a byte with a line error.
  function automatic void stage(input logic [7:0] b);
    if ($urandom_range(99) < 6)
      byte_stream.push_back(in_item_t'{8'($urandom_range(255)), 1'b1});
    byte_stream.push_back(in_item_t'{b, 1'b0});
  endfunction

  // Appends one well-formed packet with random content, or a filler byte.
  function automatic void queue_packet();
    int         pick;
    int         tries;
    int         len;
    form_t      want;
    logic [7:0] cmd;
    pick = $urandom_range(99);
    if (pick < 8) begin
      stage(8'h00);
      return;
    end
    want = (pick < 20) ? FORM_SINGLE : (pick < 45) ? FORM_TWO :
           (pick < 88) ? FORM_MULTI : FORM_UNKNOWN;
    cmd = 8'($urandom_range(1, 255));
    for (tries = 0; tries < 32 && form_of(cmd) != want; tries++)
      cmd = 8'($urandom_range(1, 255));
    stage(cmd);
    case (form_of(cmd))
      FORM_TWO: stage(8'($urandom_range(255)));
      FORM_MULTI: begin
        pick = $urandom_range(99);
        len = (pick < 6) ? 0 : (pick < 14) ? $urandom_range(MAX_PAYLOAD + 1, 255) :
              (pick < 22) ? MAX_PAYLOAD : $urandom_range(1, 6);
        stage(8'(len));
        if (len >= 1 && len <= MAX_PAYLOAD) repeat (len) stage(8'($urandom_range(255)));
      end
      default: ;
    endcase
  endfunction

  // Offers one item after a random gap and returns at the falling edge after it is taken.
  task automatic send_item(input in_item_t it, input logic typed, input logic has_ev,
                           input res_item_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= it.rx_byte;
    in_ch.line_error <= it.line_error;
    cur_typed = typed;
    cur_has_event = has_ev;
    cur_want = want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes all four registers plus one write to an index past the last register.
  task automatic program_regs(input cfg_t c);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [7:0]           val [5];
    idx = '{CFG_SIZE_CLASS_MASK, CFG_SINGLE_BYTE_CODE, CFG_TWO_BYTE_CODE,
            CFG_MULTI_BYTE_CODE,
            CFG_IDX_W'($urandom_range(int'(CFG_MULTI_BYTE_CODE) + 1, 255))};
    val = '{c.size_class_mask, c.single_byte_code, c.two_byte_code, c.multi_byte_code,
            8'($urandom_range(255))};
    foreach (idx[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data <= val[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits for every expected event, then for the items that make no event to drain.
  task automatic wait_quiet();
    while (pending_events.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Tracks register writes and accepted items, checks events and guards progress.
  always @(posedge clk) begin : observe
    res_item_t predicted;
    res_item_t want;
    res_item_t seen;
    bit        fires;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_SIZE_CLASS_MASK:  framer_regs.size_class_mask = cfg_ch.data;
          CFG_SINGLE_BYTE_CODE: framer_regs.single_byte_code = cfg_ch.data;
          CFG_TWO_BYTE_CODE:    framer_regs.two_byte_code = cfg_ch.data;
          CFG_MULTI_BYTE_CODE:  framer_regs.multi_byte_code = cfg_ch.data;
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        fires = frame_byte(in_item_t'{in_ch.rx_byte, in_ch.line_error}, predicted);
        if (cur_typed) begin
          if (cur_has_event) pending_events.push_back(cur_want);
        end else if (fires) begin
          pending_events.push_back(predicted);
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.event_kind, out_ch.command_code, out_ch.payload_index,
                 out_ch.payload_value, out_ch.packet_end};
        if (pending_events.size() == 0) begin
          $error("event with none expected: kind %0d command %0h", seen.event_kind,
                 seen.command_code);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          if (seen.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, actual %0d", want.event_kind, seen.event_kind);
            fail_count++;
          end
          if (seen.command_code !== want.command_code) begin
            $error("command_code: expected %0h, actual %0h", want.command_code,
                   seen.command_code);
            fail_count++;
          end
          if (seen.payload_index !== want.payload_index) begin
            $error("payload_index: expected %0d, actual %0d", want.payload_index,
                   seen.payload_index);
            fail_count++;
          end
          if (seen.payload_value !== want.payload_value) begin
            $error("payload_value: expected %0h, actual %0h", want.payload_value,
                   seen.payload_value);
            fail_count++;
          end
          if (seen.packet_end !== want.packet_end) begin
            $error("packet_end: expected %0d, actual %0d", want.packet_end, seen.packet_end);
            fail_count++;
          end
        end
      end

      // Watchdog on cycles without any handshake.
      if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $error("no handshake for %0d cycles, %0d events outstanding", quiet_cycles,
                 pending_events.size());
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Reset, directed table, then random phases over several register settings.
  initial begin : stimulus
    cfg_t setting;
    int   p;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    in_ch.line_error = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = 8'h00;
    out_ch.ready = 1'b0;
    cur_typed = 1'b0;
    cur_has_event = 1'b0;
    cur_want = '0;
    send_gap_pct = 24;
    recv_stall_pct = 71;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part runs on the reset values of the registers.
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].has_event,
                DIRECTED_ROWS[i].want);
    in_ch.valid <= 1'b0;

    for (p = 0; p < PHASE_COUNT; p++) begin
      // Receiver-heavy idling first, then sender-heavy, then none at all.
      case (p / 3)
        0: begin send_gap_pct = 24; recv_stall_pct = 71; end
        1: begin send_gap_pct = 71; recv_stall_pct = 24; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase

      // Register settings: defaults, extremes, overlapping codes, then random.
      case (p)
        0: setting = '{8'hC0, 8'h00, 8'h40, 8'h80};
        1: setting = '{8'hFF, 8'hFF, 8'h00, 8'h80};
        2: setting = '{8'h00, 8'h01, 8'h00, 8'hFF};
        3: setting = '{8'h03, 8'h01, 8'h01, 8'h02};
        4: setting = '{8'h30, 8'h10, 8'h20, 8'h20};
        5: setting = '{8'h00, 8'hFF, 8'hFF, 8'h00};
        6, 7: begin
          setting.size_class_mask = 8'($urandom_range(255));
          setting.single_byte_code = 8'($urandom_range(255)) & setting.size_class_mask;
          setting.two_byte_code = 8'($urandom_range(255)) & setting.size_class_mask;
          setting.multi_byte_code = 8'($urandom_range(255)) & setting.size_class_mask;
        end
        default: setting = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255))};
      endcase

      wait_quiet();
      program_regs(setting);
      @(negedge clk);

      byte_stream.delete();
      while (byte_stream.size() < PHASE_ITEMS) queue_packet();
      foreach (byte_stream[i]) send_item(byte_stream[i], 1'b0, 1'b0, '0);
      in_ch.valid <= 1'b0;
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
